[sv/bgc_pkg.sv]
// Shared widths, codes and control types of the button gesture classifier.
package bgc_pkg;

  localparam int NumButtons = 8;
  localparam int CmdW       = 2;
  localparam int BtnW       = 3;
  localparam int KindW      = 3;
  localparam int TimerW     = 16;
  localparam int EnW        = 5;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 16;
  localparam int MaxRes     = 8;
  localparam int CntW       = $clog2(MaxRes + 1);

  // Input commands; the fourth code is unused and ignored.
  localparam logic [CmdW-1:0] CMD_PRESS   = 2'd0;
  localparam logic [CmdW-1:0] CMD_RELEASE = 2'd1;
  localparam logic [CmdW-1:0] CMD_TICK    = 2'd2;

  // Event kinds.
  localparam logic [KindW-1:0] K_DOWN    = 3'd0;
  localparam logic [KindW-1:0] K_HELD    = 3'd1;
  localparam logic [KindW-1:0] K_UP      = 3'd2;
  localparam logic [KindW-1:0] K_CLICKED = 3'd3;
  localparam logic [KindW-1:0] K_SHORT   = 3'd4;
  localparam logic [KindW-1:0] K_LONG    = 3'd5;

  // Bit positions in the event enable register.
  localparam int EN_DOWN    = 0;
  localparam int EN_HELD    = 1;
  localparam int EN_UP      = 2;
  localparam int EN_CLICKED = 3;
  localparam int EN_TIMED   = 4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_EVENT_ENABLES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_LIMIT   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_LIMIT    = 2'd2;

  localparam logic [EnW-1:0]    EnablesRst    = 5'd0;
  localparam logic [TimerW-1:0] ShortLimitRst = 16'd300;
  localparam logic [TimerW-1:0] HoldLimitRst  = 16'd1000;

  // Commands from controller to datapath.
  typedef struct packed {
    logic             load;      // latch the input item
    logic             press_wr;  // restart timer, mark button down
    logic             rel_rd;    // read timer of the named button
    logic             rel_upd;   // clear down and lock of the named button
    logic             scan_rd;   // read timer at the scan index
    logic             scan_upd;  // update scanned button, may push held
    logic             push;      // push one result
    logic [KindW-1:0] kind;
    logic             flush;     // release the pending result as last
  } bgc_ctl_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic            in_range;
    logic            down;
    logic            locked;
    logic            is_short;
    logic [EnW-1:0]  en;
    logic            push_ok;
    logic            flush_ok;
    logic            scan_go;
    logic            scan_last;
  } bgc_stat_t;

endpackage

[sv/bgc_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface bgc_in_if;
  logic                     valid;
  logic                     ready;
  logic [bgc_pkg::CmdW-1:0] cmd;
  logic [bgc_pkg::BtnW-1:0] button;

  modport source (output valid, output cmd, output button, input ready);
  modport sink   (input valid, input cmd, input button, output ready);
endinterface

interface bgc_out_if;
  logic                      valid;
  logic                      ready;
  logic [bgc_pkg::BtnW-1:0]  event_button;
  logic [bgc_pkg::KindW-1:0] event_kind;
  logic                      last;

  modport source (output valid, output event_button, output event_kind, output last,
                  input ready);
  modport sink   (input valid, input event_button, input event_kind, input last,
                  output ready);
endinterface

[sv/bgc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bgc_ram #(
  parameter int Width = 16,
  parameter int Depth = 8,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/bgc_datapath.sv]
// Datapath: item latch, config registers, button flags, timer RAM, result staging.
module bgc_datapath #(
  parameter int NUM_BUTTONS = bgc_pkg::NumButtons
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bgc_pkg::bgc_ctl_t            ctl_i,
  output bgc_pkg::bgc_stat_t           stat_o,
  input  logic [bgc_pkg::CmdW-1:0]     cmd_i,
  input  logic [bgc_pkg::BtnW-1:0]     button_i,
  input  logic                         cfg_we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bgc_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bgc_pkg::BtnW-1:0]     out_button_o,
  output logic [bgc_pkg::KindW-1:0]    out_kind_o,
  output logic                         out_last_o
);
  import bgc_pkg::*;

  localparam int IdxW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_BUTTONS - 1);

  logic [CmdW-1:0]        cmd_q;
  logic [BtnW-1:0]        btn_q;
  logic [IdxW-1:0]        scan_q;
  logic [EnW-1:0]         en_q;
  logic [TimerW-1:0]      short_q;
  logic [TimerW-1:0]      hold_q;
  logic [NUM_BUTTONS-1:0] down_q;
  logic [NUM_BUTTONS-1:0] lock_q;
  logic                   pend_v_q;
  logic [BtnW-1:0]        pend_btn_q;
  logic [KindW-1:0]       pend_kind_q;
  logic                   out_v_q;
  logic [BtnW-1:0]        out_btn_q;
  logic [KindW-1:0]       out_kind_q;
  logic                   out_last_q;
  logic [CntW-1:0]        cnt_q;

  logic [IdxW-1:0]   btn_idx;
  logic [TimerW-1:0] tmr_rd;
  logic [TimerW-1:0] tmr_inc;
  logic              in_range;
  logic              scan_down;
  logic              held_fire;
  logic              full;
  logic              out_free;
  logic              push_req;
  logic              push_ok;
  logic              push_fire;
  logic              store;
  logic              flush_fire;
  logic              scan_go;
  logic [BtnW-1:0]   push_btn;
  logic [KindW-1:0]  push_kind;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [TimerW-1:0] ram_wdata;
  logic              ram_re;
  logic [IdxW-1:0]   ram_raddr;

  assign btn_idx   = IdxW'(btn_q);
  assign in_range  = int'(btn_q) < NUM_BUTTONS;
  assign tmr_inc   = (tmr_rd == '1) ? tmr_rd : tmr_rd + TimerW'(1);
  assign scan_down = down_q[scan_q];
  assign held_fire = ctl_i.scan_upd && scan_down && en_q[EN_HELD] && !lock_q[scan_q] &&
                     (tmr_inc > hold_q);

  // Result staging: one pending slot ahead of the output register, so the
  // last flag is known before a result leaves.
  assign full       = (cnt_q == CntW'(MaxRes));
  assign out_free   = !out_v_q || out_ready_i;
  assign push_req   = ctl_i.push || held_fire;
  assign push_ok    = full || !pend_v_q || out_free;
  assign push_fire  = push_req && push_ok;
  assign store      = push_fire && !full;
  assign flush_fire = ctl_i.flush && pend_v_q && out_free;
  assign scan_go    = ctl_i.scan_upd && (!held_fire || push_ok);
  assign push_btn   = ctl_i.scan_upd ? BtnW'(scan_q) : btn_q;
  assign push_kind  = ctl_i.scan_upd ? K_HELD : ctl_i.kind;

  // Timer RAM: every entry is written by a press before any read uses it.
  assign ram_we    = ctl_i.press_wr || (scan_go && scan_down);
  assign ram_waddr = ctl_i.press_wr ? btn_idx : scan_q;
  assign ram_wdata = ctl_i.press_wr ? '0 : tmr_inc;
  assign ram_re    = ctl_i.rel_rd || ctl_i.scan_rd;
  assign ram_raddr = ctl_i.rel_rd ? btn_idx : scan_q;

  bgc_ram #(
    .Width (TimerW),
    .Depth (NUM_BUTTONS)
  ) u_timer_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (tmr_rd)
  );

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q <= cmd_i;
      btn_q <= button_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q     <= EnablesRst;
      short_q  <= ShortLimitRst;
      hold_q   <= HoldLimitRst;
      down_q   <= '0;
      lock_q   <= '0;
      scan_q   <= '0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_EVENT_ENABLES: en_q    <= cfg_data_i[EnW-1:0];
          CFG_SHORT_LIMIT:   short_q <= cfg_data_i[TimerW-1:0];
          CFG_HOLD_LIMIT:    hold_q  <= cfg_data_i[TimerW-1:0];
          default: ;
        endcase
      end
      if (ctl_i.press_wr) begin
        down_q[btn_idx] <= 1'b1;
      end
      if (ctl_i.rel_upd) begin
        down_q[btn_idx] <= 1'b0;
        lock_q[btn_idx] <= 1'b0;
      end
      if (scan_go && held_fire) begin
        lock_q[scan_q] <= 1'b1;
      end
      if (ctl_i.load) begin
        scan_q <= '0;
        cnt_q  <= '0;
      end else begin
        if (scan_go) begin
          scan_q <= scan_q + IdxW'(1);
        end
        if (store) begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (store) begin
        pend_v_q <= 1'b1;
      end else if (flush_fire) begin
        pend_v_q <= 1'b0;
      end
      if ((store && pend_v_q) || flush_fire) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      pend_btn_q  <= push_btn;
      pend_kind_q <= push_kind;
    end
    if ((store && pend_v_q) || flush_fire) begin
      out_btn_q  <= pend_btn_q;
      out_kind_q <= pend_kind_q;
      out_last_q <= flush_fire;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.in_range  = in_range;
  assign stat_o.down      = down_q[btn_idx];
  assign stat_o.locked    = lock_q[btn_idx];
  assign stat_o.is_short  = (tmr_rd <= short_q);
  assign stat_o.en        = en_q;
  assign stat_o.push_ok   = push_ok;
  assign stat_o.flush_ok  = !pend_v_q || out_free;
  assign stat_o.scan_go   = scan_go;
  assign stat_o.scan_last = (scan_q == LastIdx);

  assign out_valid_o  = out_v_q;
  assign out_button_o = out_btn_q;
  assign out_kind_o   = out_kind_q;
  assign out_last_o   = out_last_q;

endmodule

[sv/bgc_ctrl.sv]
// Controller: sequences press, release and tick handling over the datapath.
module bgc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bgc_pkg::bgc_stat_t  stat_i,
  output bgc_pkg::bgc_ctl_t   ctl_o
);
  import bgc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PRESS,
    S_REL_EVAL,
    S_REL_UP,
    S_REL_CLK,
    S_REL_TMD,
    S_TICK_RD,
    S_TICK_EVAL,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    ctl_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        ctl_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat_i.cmd)
          CMD_PRESS: begin
            if (stat_i.in_range) begin
              ctl_o.press_wr = 1'b1;
              state_d        = S_PRESS;
            end else begin
              state_d = S_IDLE;
            end
          end
          CMD_RELEASE: begin
            if (stat_i.in_range && stat_i.down) begin
              ctl_o.rel_rd = 1'b1;
              state_d      = S_REL_EVAL;
            end else begin
              state_d = S_IDLE;
            end
          end
          CMD_TICK: state_d = S_TICK_RD;
          default:  state_d = S_IDLE;
        endcase
      end
      S_PRESS: begin
        ctl_o.push = stat_i.en[EN_DOWN];
        ctl_o.kind = K_DOWN;
        if (!ctl_o.push || stat_i.push_ok) begin
          state_d = S_FLUSH;
        end
      end
      S_REL_EVAL: begin
        // A locked button drops its lock and down flag but pushes no events.
        ctl_o.rel_upd = 1'b1;
        state_d       = stat_i.locked ? S_IDLE : S_REL_UP;
      end
      S_REL_UP: begin
        ctl_o.push = stat_i.en[EN_UP];
        ctl_o.kind = K_UP;
        if (!ctl_o.push || stat_i.push_ok) begin
          state_d = S_REL_CLK;
        end
      end
      S_REL_CLK: begin
        ctl_o.push = stat_i.en[EN_CLICKED];
        ctl_o.kind = K_CLICKED;
        if (!ctl_o.push || stat_i.push_ok) begin
          state_d = S_REL_TMD;
        end
      end
      S_REL_TMD: begin
        ctl_o.push = stat_i.en[EN_TIMED];
        ctl_o.kind = stat_i.is_short ? K_SHORT : K_LONG;
        if (!ctl_o.push || stat_i.push_ok) begin
          state_d = S_FLUSH;
        end
      end
      S_TICK_RD: begin
        ctl_o.scan_rd = 1'b1;
        state_d       = S_TICK_EVAL;
      end
      S_TICK_EVAL: begin
        ctl_o.scan_upd = 1'b1;
        if (stat_i.scan_go) begin
          state_d = stat_i.scan_last ? S_FLUSH : S_TICK_RD;
        end
      end
      S_FLUSH: begin
        ctl_o.flush = 1'b1;
        if (stat_i.flush_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

[sv/button_gesture_classifier.sv]
// Button gesture classifier: per-button press timers with down/held/up/click/short/long events.
// Each item is decoded, walked through its press, release or tick states, and its
// last result flushed into the output register; output stalls hold it up.
// Throughput: one item at a time; the timer RAM port and the per-button scan set it.
// Reset: async, active low; clears all flags and loads register defaults. Timer
// RAM is not cleared: a press always writes an entry before it is read.
module button_gesture_classifier #(
  parameter int NUM_BUTTONS = bgc_pkg::NumButtons
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bgc_in_if.sink                       in_ch,
  bgc_out_if.source                    out_ch,
  input  logic                         cfg_we_i,
  input  logic [bgc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bgc_pkg::CfgDataW-1:0] cfg_data_i
);
  import bgc_pkg::*;

  // Controller and datapath talk only through these two bundles.
  bgc_ctl_t  ctl;
  bgc_stat_t stat;
  logic      in_ready;

  // Controller: take one input transfer, walk it through press, release or
  // tick steps, then flush the final result with its last flag set.
  bgc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  assign in_ch.ready = in_ready;

  // Datapath: holds the item, the config, the flags and timer RAM, and a
  // pending slot plus output register so a result can wait while the next
  // item is taken.
  bgc_datapath #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .cmd_i        (in_ch.cmd),
    .button_i     (in_ch.button),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_button_o (out_ch.event_button),
    .out_kind_o   (out_ch.event_kind),
    .out_last_o   (out_ch.last)
  );

endmodule

[dv/button_gesture_classifier_tb.sv]
// Self-checking testbench for the button gesture classifier with a behavioral predictor.
`timescale 1ns / 100ps

module button_gesture_classifier_tb;
  import bgc_pkg::*;

  // The package names no code for the fourth command; the block must ignore it.
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;

  // Idle cycles with no transfer on either channel before the run is declared hung.
  localparam int HangLimit = 5000;
  // Drain time after the last expected event: a full scan plus margin.
  localparam int DrainCycles = 2 * NumButtons + 10;

  typedef struct packed {
    logic [CmdW-1:0] cmd;
    logic [BtnW-1:0] btn;
  } key_t;

  typedef struct packed {
    logic [BtnW-1:0]  btn;
    logic [KindW-1:0] kind;
    logic             last;
  } gesture_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = CFG_EVENT_ENABLES;
  logic [CfgDataW-1:0] cfg_data = '0;

  bgc_in_if  in_ch ();
  bgc_out_if out_ch ();

  button_gesture_classifier dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk = ~clk;

  // Predictor state: per-button timers and flags, plus the shadow register file.
  logic [TimerW-1:0]     timer_ticks [NumButtons];
  logic [NumButtons-1:0] held_down;
  logic [NumButtons-1:0] hold_lock;
  logic [EnW-1:0]        en_mask;
  logic [TimerW-1:0]     short_ticks;
  logic [TimerW-1:0]     hold_ticks;

  key_t     pending_keys [$];
  gesture_t expected_events [$];

  // Buttons the stimulus generator believes are down, to build well-formed press/release pairs.
  logic [NumButtons-1:0] gen_down = '0;

  int mismatch_count = 0;
  int idle_cycles    = 0;

  function automatic gesture_t make_event(input logic [BtnW-1:0] btn,
                                          input logic [KindW-1:0] kind);
    gesture_t ev;
    ev.btn  = btn;
    ev.kind = kind;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Advance the predictor by one accepted key item and queue the events it causes.
  task automatic classify_key(input logic [CmdW-1:0] cmd, input logic [BtnW-1:0] btn);
    gesture_t found [$];
    case (cmd)
      CMD_PRESS: begin
        if (int'(btn) < NumButtons) begin
          // A press while down restarts the timer but keeps the lock.
          held_down[btn]   = 1'b1;
          timer_ticks[btn] = '0;
          if (en_mask[EN_DOWN]) found = {found, make_event(btn, K_DOWN)};
        end
      end
      CMD_RELEASE: begin
        // Drop releases of buttons that are not down.
        if (int'(btn) < NumButtons && held_down[btn]) begin
          held_down[btn] = 1'b0;
          if (hold_lock[btn]) begin
            // A locked button already reported held; only clear the lock.
            hold_lock[btn] = 1'b0;
          end else begin
            if (en_mask[EN_UP]) found = {found, make_event(btn, K_UP)};
            if (en_mask[EN_CLICKED]) found = {found, make_event(btn, K_CLICKED)};
            if (en_mask[EN_TIMED]) begin
              found = {found, make_event(btn, (timer_ticks[btn] <= short_ticks) ?
                                              K_SHORT : K_LONG)};
            end
          end
        end
      end
      CMD_TICK: begin
        // Scan upward: saturate-increment first, then compare against the hold limit.
        for (int i = 0; i < NumButtons; i++) begin
          if (held_down[i]) begin
            if (timer_ticks[i] != '1) timer_ticks[i] = timer_ticks[i] + 1'b1;
            if (en_mask[EN_HELD] && !hold_lock[i] && timer_ticks[i] > hold_ticks) begin
              hold_lock[i] = 1'b1;
              found = {found, make_event(BtnW'(i), K_HELD)};
            end
          end
        end
      end
      default: ;
    endcase
    if (found.size() != 0) found[found.size() - 1].last = 1'b1;
    foreach (found[k]) expected_events = {expected_events, found[k]};
  endtask

  task automatic queue_key(input logic [CmdW-1:0] cmd, input logic [BtnW-1:0] btn);
    key_t k;
    k.cmd = cmd;
    k.btn = btn;
    pending_keys = {pending_keys, k};
    if (cmd == CMD_PRESS) gen_down[btn] = 1'b1;
    if (cmd == CMD_RELEASE) gen_down[btn] = 1'b0;
  endtask

  // The button field is ignored on a tick; fill it with noise anyway.
  task automatic queue_ticks(input int n);
    repeat (n) queue_key(CMD_TICK, BtnW'($urandom_range(0, NumButtons - 1)));
  endtask

  // Mostly press/tick/release of real buttons, with stray releases and unused codes as noise.
  task automatic queue_random_keys(input int n);
    int                pick;
    logic [BtnW-1:0]   btn;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      btn  = BtnW'($urandom_range(0, NumButtons - 1));
      if (pick < 28) begin
        queue_key(CMD_PRESS, btn);
      end else if (pick < 58) begin
        if (gen_down != '0 && $urandom_range(0, 99) < 85) begin
          while (!gen_down[btn]) btn = BtnW'($urandom_range(0, NumButtons - 1));
        end
        queue_key(CMD_RELEASE, btn);
      end else if (pick < 95) begin
        queue_ticks(1);
      end else begin
        queue_key(CMD_UNUSED, btn);
      end
    end
  endtask

  // Write all three registers back to back, then drop the write enable once.
  task automatic program_regs(input logic [EnW-1:0] en, input logic [TimerW-1:0] short_lim,
                              input logic [TimerW-1:0] hold_lim);
    logic [CfgDataW-1:0] en_word;
    en_word          = CfgDataW'($urandom);
    en_word[EnW-1:0] = en;
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_EVENT_ENABLES;
    cfg_data <= en_word;
    @(posedge clk);
    cfg_idx  <= CFG_SHORT_LIMIT;
    cfg_data <= short_lim;
    @(posedge clk);
    cfg_idx  <= CFG_HOLD_LIMIT;
    cfg_data <= hold_lim;
    @(posedge clk);
    cfg_we <= 1'b0;
    en_mask     = en;
    short_ticks = short_lim;
    hold_ticks  = hold_lim;
  endtask

  // Wait until every key is taken and every event has come back, then let a scan finish.
  task automatic settle();
    while (pending_keys.size() != 0 || in_ch.valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Key driver: bursts of random length separated by random gaps.
  int   burst_left;
  int   gap_left;
  key_t next_key;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left  <= 0;
      gap_left    <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_keys.size() != 0) begin
        next_key      = pending_keys.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.cmd    <= next_key.cmd;
        in_ch.button <= next_key.btn;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 11);
          // Leave some bursts back to back with no gap at all.
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Event receiver: ready follows an 8-bit stall pattern, reloaded each time the phase counter wraps.
  logic [7:0] stall_pattern;
  logic [4:0] stall_phase;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready  <= 1'b0;
      stall_pattern <= 8'hFF;
      stall_phase   <= '0;
    end else begin
      if (stall_phase == '1) begin
        case ($urandom_range(0, 3))
          0:       stall_pattern <= 8'hFF;
          1:       stall_pattern <= 8'h01;
          default: stall_pattern <= 8'($urandom) | 8'h01;
        endcase
      end
      out_ch.ready <= stall_pattern[stall_phase[2:0]];
      stall_phase  <= stall_phase + 1'b1;
    end
  end

  // Monitor: predict on each key transfer, score each event transfer, watch for a hang.
  gesture_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) classify_key(in_ch.cmd, in_ch.button);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_events.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected event: expected none, got btn %0d kind %0d last %0d",
                   $realtime, out_ch.event_button, out_ch.event_kind, out_ch.last);
        end else begin
          want = expected_events.pop_front();
          if (out_ch.event_button !== want.btn || out_ch.event_kind !== want.kind ||
              out_ch.last !== want.last) begin
            mismatch_count++;
            $display("%0t: event mismatch: expected btn %0d kind %0d last %0d, %s",
                     $realtime, want.btn, want.kind, want.last, "got:");
            $display("%0t:   got btn %0d kind %0d last %0d",
                     $realtime, out_ch.event_button, out_ch.event_kind, out_ch.last);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= HangLimit) begin
        $display("%0t: no transfer for %0d cycles", $realtime, HangLimit);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  logic [EnW-1:0]    phase_en;
  logic [TimerW-1:0] phase_short;
  logic [TimerW-1:0] phase_hold;

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_PRESS;
    in_ch.button  = '0;
    out_ch.ready  = 1'b0;
    held_down     = '0;
    hold_lock     = '0;
    foreach (timer_ticks[i]) timer_ticks[i] = '0;
    en_mask       = EnablesRst;
    short_ticks   = ShortLimitRst;
    hold_ticks    = HoldLimitRst;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults enable nothing: a full press/tick/release must stay silent.
    queue_key(CMD_PRESS, 3'd5);
    queue_ticks(1);
    queue_key(CMD_RELEASE, 3'd5);
    settle();

    // Directed: every event kind, lock behavior and the ignored cases.
    program_regs('1, 16'd2, 16'd3);
    queue_key(CMD_PRESS, 3'd0);
    queue_key(CMD_PRESS, 3'd7);
    queue_key(CMD_RELEASE, 3'd7);        // timer at zero: short click
    queue_ticks(3);                      // timer equals the hold limit: no held yet
    queue_ticks(1);                      // exceeds it: held, button locks
    queue_ticks(1);                      // held fires once per press
    queue_key(CMD_PRESS, 3'd0);          // press while down keeps the lock
    queue_ticks(4);
    queue_key(CMD_RELEASE, 3'd0);        // locked: release clears down and the lock, no events
    queue_key(CMD_RELEASE, 3'd0);        // not down: ignored
    queue_key(CMD_PRESS, 3'd3);
    queue_ticks(3);
    queue_key(CMD_RELEASE, 3'd3);        // past the short limit: long click
    queue_key(CMD_UNUSED, 3'd6);
    settle();

    // Random phases; reprogram between them, hitting both ends of every register.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       phase_hold = '0;
        1:       phase_hold = '1;
        default: phase_hold = TimerW'($urandom_range(1, 12));
      endcase
      case (phase % 3)
        0:       phase_short = '0;
        1:       phase_short = '1;
        default: phase_short = TimerW'($urandom_range(1, 10));
      endcase
      if (phase == 0 || phase == 5) phase_en = '1;
      else if (phase == 3) phase_en = '0;
      else phase_en = EnW'($urandom_range(0, 31));
      program_regs(phase_en, phase_short, phase_hold);
      queue_random_keys(53);
      settle();
    end

    if (expected_events.size() != 0) begin
      mismatch_count++;
      $display("%0t: %0d expected events never arrived", $realtime, expected_events.size());
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[button_gesture_classifier.f]
sv/bgc_pkg.sv
sv/bgc_if.sv
sv/bgc_ram.sv
sv/bgc_datapath.sv
sv/bgc_ctrl.sv
sv/button_gesture_classifier.sv
dv/button_gesture_classifier_tb.sv
